>>> rtl/core/estb_pkg.sv
`default_nettype none

package estb_pkg;

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   localparam logic [2:0] REG_SETPOINT_MIN   = 3'd0;
   localparam logic [2:0] REG_SETPOINT_MAX   = 3'd1;
   localparam logic [2:0] REG_SETPOINT_STEP  = 3'd2;
   localparam logic [2:0] REG_DEBOUNCE_TICKS = 3'd3;
   localparam logic [2:0] REG_DETENT_COUNTS  = 3'd4;

   localparam logic [8:0] SETPOINT_MIN_RST   = 9'd60;
   localparam logic [8:0] SETPOINT_MAX_RST   = 9'd260;
   localparam logic [5:0] SETPOINT_STEP_RST  = 6'd5;
   localparam logic [5:0] DEBOUNCE_TICKS_RST = 6'd40;
   localparam logic [2:0] DETENT_COUNTS_RST  = 3'd4;

   localparam logic [1:0] QUAD_RST     = 2'd3;
   localparam logic [8:0] SETPOINT_RST = 9'd100;
   localparam logic [5:0] TICKS_MAX    = 6'd63;

   typedef struct packed {
      logic [8:0] setpoint_value;
      logic       drive_enabled;
   } result_type;

   // transition table indexed by {previous, current}
   function automatic logic signed [1:0] quad_delta(input logic [3:0] idx);
      logic signed [1:0] d;
      case (idx)
         4'd1, 4'd7, 4'd8, 4'd14: d = -2'sd1;
         4'd2, 4'd4, 4'd11, 4'd13: d = 2'sd1;
         default: d = 2'sd0;
      endcase
      return d;
   endfunction

endpackage

`default_nettype wire

>>> rtl/core/encoder_setpoint_and_toggle_button.sv
// an accepted req word's rsp word is registered in out_ff, or in skid_ff while out_ff holds a waiting word
// throughput: one word per cycle while req_stall is low; all state updates happen in one pass
// a two-entry output buffer keeps req open while one rsp word waits
// reset: synchronous, active high; restores the default limits, step, debounce
// and detent settings, setpoint 100, drive off, switch released
`default_nettype none

module encoder_setpoint_and_toggle_button (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire logic                            req_quad_a,
   input  wire logic                            req_quad_b,
   input  wire logic                            req_switch_level,
   input  wire logic                            req_sensor_fault,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic [8:0]                           rsp_setpoint_value,
   output logic                                 rsp_drive_enabled,
   input  wire logic                            csr_psel,
   input  wire logic                            csr_penable,
   input  wire logic                            csr_pwrite,
   input  wire logic [estb_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [estb_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [estb_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                 csr_pready
);

   logic [8:0] sp_min_ff;
   logic [8:0] sp_max_ff;
   logic [5:0] sp_step_ff;
   logic [5:0] deb_ticks_ff;
   logic [2:0] detent_ff;

   logic [1:0]        last_quad_ff, last_quad_in;
   logic signed [3:0] count_ff, count_in;
   logic [8:0]        setpoint_ff, setpoint_in;
   logic              raw_sw_ff, raw_sw_in;
   logic              stable_sw_ff, stable_sw_in;
   logic [5:0]        ticks_ff, ticks_in;
   logic              drive_ff, drive_in;

   estb_pkg::result_type out_ff, out_in;
   estb_pkg::result_type skid_ff, skid_in;
   estb_pkg::result_type result;
   logic out_valid_ff, out_valid_in;
   logic skid_valid_ff, skid_valid_in;

   logic              req_take;
   logic              rsp_take;
   logic              csr_write;
   logic [2:0]        csr_index;
   logic [1:0]        cur_quad;
   logic signed [4:0] count_sum;
   logic signed [4:0] thresh;
   logic              step_hit;
   logic signed [10:0] sp_new;
   logic signed [10:0] sp_lo;
   logic signed [10:0] sp_hi;
   logic              sw_accept;

   assign req_take  = req_valid && !req_stall;
   assign rsp_take  = out_valid_ff && !rsp_stall;
   assign req_stall = skid_valid_ff;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_paddr[4:2];

   always_comb begin
      case (csr_index)
         estb_pkg::REG_SETPOINT_MIN:   csr_prdata = {23'd0, sp_min_ff};
         estb_pkg::REG_SETPOINT_MAX:   csr_prdata = {23'd0, sp_max_ff};
         estb_pkg::REG_SETPOINT_STEP:  csr_prdata = {26'd0, sp_step_ff};
         estb_pkg::REG_DEBOUNCE_TICKS: csr_prdata = {26'd0, deb_ticks_ff};
         estb_pkg::REG_DETENT_COUNTS:  csr_prdata = {29'd0, detent_ff};
         default:                      csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sp_min_ff    <= estb_pkg::SETPOINT_MIN_RST;
         sp_max_ff    <= estb_pkg::SETPOINT_MAX_RST;
         sp_step_ff   <= estb_pkg::SETPOINT_STEP_RST;
         deb_ticks_ff <= estb_pkg::DEBOUNCE_TICKS_RST;
         detent_ff    <= estb_pkg::DETENT_COUNTS_RST;
      end else if (csr_write) begin
         case (csr_index)
            estb_pkg::REG_SETPOINT_MIN:   sp_min_ff    <= csr_pwdata[8:0];
            estb_pkg::REG_SETPOINT_MAX:   sp_max_ff    <= csr_pwdata[8:0];
            estb_pkg::REG_SETPOINT_STEP:  sp_step_ff   <= csr_pwdata[5:0];
            estb_pkg::REG_DEBOUNCE_TICKS: deb_ticks_ff <= csr_pwdata[5:0];
            estb_pkg::REG_DETENT_COUNTS:  detent_ff    <= csr_pwdata[2:0];
            default: ;
         endcase
      end
   end

   // quadrature decode and setpoint step
   always_comb begin
      cur_quad     = {req_quad_a, req_quad_b};
      count_sum    = 5'(count_ff) + 5'(estb_pkg::quad_delta({last_quad_ff, cur_quad}));
      thresh       = signed'({2'b00, detent_ff});
      step_hit     = (count_sum >= thresh) || (count_sum <= -thresh);
      sp_lo        = signed'({2'b00, sp_min_ff});
      sp_hi        = signed'({2'b00, sp_max_ff});
      if (count_sum > 5'sd0) begin
         sp_new = signed'({2'b00, setpoint_ff}) + signed'({5'd0, sp_step_ff});
      end else begin
         sp_new = signed'({2'b00, setpoint_ff}) - signed'({5'd0, sp_step_ff});
      end
      if (sp_new < sp_lo) begin
         sp_new = sp_lo;
      end else if (sp_new > sp_hi) begin
         sp_new = sp_hi;
      end
      last_quad_in = last_quad_ff;
      count_in     = count_ff;
      setpoint_in  = setpoint_ff;
      if (cur_quad != last_quad_ff) begin
         last_quad_in = cur_quad;
         if (step_hit) begin
            setpoint_in = sp_new[8:0];
            count_in    = 4'sd0;
         end else begin
            count_in = count_sum[3:0];
         end
      end
   end

   // switch debounce and drive toggle
   always_comb begin
      raw_sw_in = req_switch_level;
      if (req_switch_level != raw_sw_ff) begin
         ticks_in = '0;
      end else if (ticks_ff < estb_pkg::TICKS_MAX) begin
         ticks_in = ticks_ff + 6'd1;
      end else begin
         ticks_in = ticks_ff;
      end
      sw_accept    = (raw_sw_in != stable_sw_ff) && (ticks_in >= deb_ticks_ff);
      stable_sw_in = sw_accept ? raw_sw_in : stable_sw_ff;
      drive_in     = drive_ff ^ (sw_accept && !raw_sw_in);
      if (req_sensor_fault) begin
         drive_in = 1'b0;
      end
      result.setpoint_value = setpoint_in;
      result.drive_enabled  = drive_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_quad_ff <= estb_pkg::QUAD_RST;
         count_ff     <= '0;
         setpoint_ff  <= estb_pkg::SETPOINT_RST;
         raw_sw_ff    <= 1'b1;
         stable_sw_ff <= 1'b1;
         ticks_ff     <= '0;
         drive_ff     <= 1'b0;
      end else if (req_take) begin
         last_quad_ff <= last_quad_in;
         count_ff     <= count_in;
         setpoint_ff  <= setpoint_in;
         raw_sw_ff    <= raw_sw_in;
         stable_sw_ff <= stable_sw_in;
         ticks_ff     <= ticks_in;
         drive_ff     <= drive_in;
      end
   end

   // output register with one skid entry
   always_comb begin
      out_in        = out_ff;
      out_valid_in  = out_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (rsp_take) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            out_in       = result;
            out_valid_in = req_take;
         end
      end else if (!out_valid_ff) begin
         out_in       = result;
         out_valid_in = req_take;
      end else if (req_take) begin
         skid_in       = result;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_setpoint_value = out_ff.setpoint_value;
   assign rsp_drive_enabled  = out_ff.drive_enabled;

endmodule

`default_nettype wire
